// ----- src/encoder_angle_tracking_observer_defines.svh -----
// Assertion macros for the encoder angle tracking observer.
`ifndef ENCODER_ANGLE_TRACKING_OBSERVER_DEFINES_SVH
`define ENCODER_ANGLE_TRACKING_OBSERVER_DEFINES_SVH

// same-cycle implication
`define EATO_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("eato: same-cycle check failed");

// next-cycle implication
`define EATO_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("eato: next-cycle check failed");

`endif

// ----- src/eato_pkg.sv -----
// Shared types, constants and helpers for the encoder angle tracking observer.
`default_nettype none

package eato_pkg;

    localparam int FRAME_W    = 16;
    localparam int ERR_BIT    = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CPR_REG_W  = 15;
    localparam int CPR_W      = 17;
    localparam int POS_W      = 48;
    localparam int VEL_W      = 40;
    localparam int TURNS_W    = 32;
    localparam int COUNT_W    = 32;
    localparam int MISSED_W   = 16;
    localparam int OUT_W      = 120;
    localparam int OUT_PAD_W  = 6;

    // multiplier datapath
    localparam int XW         = 50;
    localparam int MAG_W      = 48;
    localparam int HALF_W     = 24;
    localparam int B_W        = 32;
    localparam int PP_W       = HALF_W + B_W;
    localparam int ACC_W      = PP_W + HALF_W;
    localparam int CAP_BITS   = 50;
    localparam int RES_W      = CAP_BITS + 2;
    localparam int LONG_SHIFT = 32;
    localparam int SUM_W      = RES_W + 1;
    localparam int DB_W       = 64;
    localparam int DB_SHIFT   = 17;
    localparam int VCOR_SHIFT = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_GAIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CPR        = 3'd4;

    localparam logic [CPR_REG_W-1:0]  CPR_RESET       = 15'd16384;
    localparam logic [CFG_DATA_W-1:0] STEP_TIME_RESET = 32'd429497;
    localparam logic [CFG_DATA_W-1:0] POS_GAIN_RESET  = 32'd3355443;
    localparam logic [CFG_DATA_W-1:0] VEL_GAIN_RESET  = 32'd6553600;
    localparam logic [CFG_DATA_W-1:0] INV_CPR_RESET   = 32'd262144;

    localparam logic [MISSED_W-1:0] MISSED_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_REM,
        S_UNWRAP,
        S_ERR,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_PRED,
        OP_PCOR,
        OP_VCOR,
        OP_POUT,
        OP_VOUT
    } op_t;

    typedef enum logic [2:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_SUM,
        MP_OUT
    } mul_phase_t;

    typedef struct packed {
        logic                  start;
        logic                  short_shift;
        logic [B_W-1:0]        b;
        logic signed [XW-1:0]  x;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [RES_W-1:0] result;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [CPR_W-1:0]   divisor;
        logic [FRAME_W-1:0] dividend;
    } rem_req_t;

    typedef struct packed {
        logic             done;
        logic [CPR_W-1:0] remainder;
    } rem_rsp_t;

    function automatic logic signed [SUM_W-1:0] sat_w(input logic signed [SUM_W-1:0] v,
                                                      input int unsigned w);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = signed'((SUM_W'(1) << (w - 1)) - SUM_W'(1));
        lo = ~hi;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

endpackage

`default_nettype wire

// ----- src/eato_mul.sv -----
// Shared sign-magnitude multiplier: 48x32 in two 24x32 halves, shift, cap, sign.
`default_nettype none

module eato_mul
    import eato_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    localparam int SHORT_SHIFT = 24 - FRAC_BITS;
    localparam logic [ACC_W-1:0] CAP = ACC_W'(1) << CAP_BITS;

    mul_phase_t              phase_reg;
    mul_phase_t              phase_next;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [B_W-1:0]          b_reg;
    logic                    short_reg;
    logic [PP_W-1:0]         pp_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic signed [RES_W-1:0] res_reg;
    logic                    done_reg;

    logic [XW-1:0]           x_abs;
    logic [PP_W-1:0]         pp_next;
    logic [ACC_W-1:0]        acc_shift;
    logic [CAP_BITS:0]       mag_cap;
    logic signed [RES_W-1:0] res_next;

    always_comb begin
        x_abs     = req.x[XW-1] ? -req.x : req.x;
        pp_next   = (phase_reg == MP_LO) ? mag_reg[HALF_W-1:0] * b_reg
                                         : mag_reg[MAG_W-1:HALF_W] * b_reg;
        acc_shift = short_reg ? (acc_reg >> SHORT_SHIFT) : (acc_reg >> LONG_SHIFT);
        mag_cap   = (acc_shift > CAP) ? CAP[CAP_BITS:0] : acc_shift[CAP_BITS:0];
        res_next  = neg_reg ? -signed'({1'b0, mag_cap}) : signed'({1'b0, mag_cap});
    end

    always_comb begin
        case (phase_reg)
            MP_IDLE: phase_next = req.start ? MP_LO : MP_IDLE;
            MP_LO:   phase_next = MP_HI;
            MP_HI:   phase_next = MP_SUM;
            MP_SUM:  phase_next = MP_OUT;
            MP_OUT:  phase_next = MP_IDLE;
            default: phase_next = MP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == MP_OUT);
        end
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            MP_IDLE: begin
                if (req.start) begin
                    mag_reg   <= x_abs[MAG_W-1:0];
                    neg_reg   <= req.x[XW-1];
                    b_reg     <= req.b;
                    short_reg <= req.short_shift;
                end
            end
            MP_LO: begin
                pp_reg <= pp_next;
            end
            MP_HI: begin
                acc_reg <= ACC_W'(pp_reg);
                pp_reg  <= pp_next;
            end
            MP_SUM: begin
                acc_reg <= acc_reg + {pp_reg, HALF_W'(0)};
            end
            MP_OUT: begin
                res_reg <= res_next;
            end
            default: ;
        endcase
    end

    assign rsp = '{done: done_reg, result: res_reg};

endmodule

`default_nettype wire

// ----- src/eato_rem.sv -----
// Restoring remainder unit, one dividend bit per cycle, for the angle wrap.
`default_nettype none

module eato_rem
    import eato_pkg::*;
#(
    parameter int ANGLE_BITS = 14
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire rem_req_t req,
    output rem_rsp_t      rsp
);

    localparam int CNT_W = $clog2(ANGLE_BITS + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [CPR_W-1:0]      rem_reg;
    logic [ANGLE_BITS-1:0] dq_reg;
    logic [CPR_W-1:0]      div_reg;

    logic [CPR_W:0]        trial;
    logic [CPR_W:0]        trial_sub;
    logic                  fits;

    always_comb begin
        trial     = {rem_reg, dq_reg[ANGLE_BITS-1]};
        fits      = trial >= {1'b0, div_reg};
        trial_sub = trial - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (req.start) begin
                cnt_reg <= CNT_W'(ANGLE_BITS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            dq_reg  <= req.dividend[ANGLE_BITS-1:0];
            div_reg <= req.divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? trial_sub[CPR_W-1:0] : trial[CPR_W-1:0];
            dq_reg  <= dq_reg << 1;
        end
    end

    assign rsp = '{done: done_reg, remainder: rem_reg};

endmodule

`default_nettype wire

// ----- src/encoder_angle_tracking_observer.sv -----
// Top level of the encoder angle tracking observer: sequencer, state and ports.
`default_nettype none
`include "encoder_angle_tracking_observer_defines.svh"

// One transaction on the s_ side is one control tick and yields exactly one transaction on the
// m_ side. The tick is sequenced over one shared 24x32 multiplier. A tick without an accepted
// frame runs three products; a tick with an accepted frame adds two correction products, the
// bitwise angle-wrap remainder and the S_UNWRAP and S_ERR states. s_tready is high only
// between ticks; a finished result waits in the output register, so the next tick is taken
// while it is pending, and a tick finishing while that register is still full holds until
// the pending transaction is taken. Configuration writes land at once and should be made
// between ticks. A counts_per_rev of zero acts as one full revolution of 2^ANGLE_BITS counts.
module encoder_angle_tracking_observer
    import eato_pkg::*;
#(
    parameter int ANGLE_BITS = 14,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [FRAME_W-1:0]    s_tdata,   // [15:0] frame
    input  wire logic                  s_tuser,   // [0] frame_present

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [31:0] position_turns, [63:32] velocity_turns, [95:64] total_count,
    // [96] frame_rejected, [97] error_seen, [113:98] missed_updates, [119:114] zero
    output logic [OUT_W-1:0]           m_tdata
);

    state_t                    state_reg;
    state_t                    state_next;
    op_t                       op_reg;
    op_t                       op_next;

    logic [CPR_REG_W-1:0]      cpr_reg;
    logic [CFG_DATA_W-1:0]     step_time_reg;
    logic [CFG_DATA_W-1:0]     pos_gain_reg;
    logic [CFG_DATA_W-1:0]     vel_gain_reg;
    logic [CFG_DATA_W-1:0]     inv_cpr_reg;

    logic [ANGLE_BITS-1:0]     last_angle_reg;
    logic [ANGLE_BITS-1:0]     angle_reg;
    logic [ANGLE_BITS-1:0]     dmag_reg;
    logic                      dneg_reg;
    logic                      accepted_reg;
    logic                      rejected_reg;
    logic                      error_reg;
    logic [MISSED_W-1:0]       missed_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic signed [POS_W-1:0]   pos_reg;
    logic signed [VEL_W-1:0]   vel_reg;
    logic signed [XW-1:0]      err_reg;
    logic [TURNS_W-1:0]        pos_turns_reg;
    logic [TURNS_W-1:0]        vel_turns_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [TURNS_W-1:0]        out_pos_reg;
    logic [TURNS_W-1:0]        out_vel_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic                      out_rej_reg;
    logic                      out_err_reg;
    logic [MISSED_W-1:0]       out_missed_reg;

    mul_req_t                  mul_req;
    mul_rsp_t                  mul_rsp;
    rem_req_t                  rem_req;
    rem_rsp_t                  rem_rsp;
    logic                      mul_start;
    logic                      rem_start;
    logic                      load_out;

    logic                      take_in;
    logic [ANGLE_BITS-1:0]     in_angle;
    logic                      in_rej;
    logic                      in_acc;
    logic signed [ANGLE_BITS:0] d_val;
    logic [ANGLE_BITS:0]       d_abs;
    logic [VEL_W-1:0]          vmag;
    logic [DB_W-1:0]           db_lhs;
    logic [DB_W-1:0]           db_rhs;
    logic [CPR_W-1:0]          cpr;
    logic [CPR_W-1:0]          rem_r;
    logic [CPR_W-1:0]          m1;
    logic signed [CPR_W:0]     m_val;
    logic signed [XW-1:0]      err_val;
    logic signed [RES_W-1:0]   mul_res;
    logic signed [SUM_W-1:0]   pos_sum;
    logic signed [SUM_W-1:0]   vel_sum;
    logic signed [SUM_W-1:0]   pos_sat;
    logic signed [SUM_W-1:0]   vel_sat;
    logic signed [SUM_W-1:0]   turns_sat;

    eato_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    eato_rem #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign take_in  = s_tvalid && s_tready;

    always_comb begin
        in_angle = s_tdata[ANGLE_BITS-1:0];
        in_rej   = s_tuser && (s_tdata[ERR_BIT] || (^s_tdata));
        in_acc   = s_tuser && !in_rej;
        d_val    = signed'({1'b0, in_angle}) - signed'({1'b0, last_angle_reg});
        d_abs    = d_val[ANGLE_BITS] ? -d_val : d_val;
        vmag     = vel_reg[VEL_W-1] ? -vel_reg : vel_reg;
        db_lhs   = DB_W'(vmag) << DB_SHIFT;
        db_rhs   = DB_W'(vel_gain_reg) << FRAC_BITS;

        cpr      = (cpr_reg == '0) ? (CPR_W'(1) << ANGLE_BITS) : CPR_W'(cpr_reg);
        rem_r    = rem_rsp.remainder;
        m1       = (dneg_reg && rem_r != '0) ? cpr - rem_r : rem_r;
        m_val    = ({m1, 1'b0} > {1'b0, cpr}) ? signed'({1'b0, m1}) - signed'({1'b0, cpr})
                                              : signed'({1'b0, m1});
        err_val  = XW'(signed'(count_reg)) - XW'(pos_reg >>> FRAC_BITS);

        mul_res   = mul_rsp.result;
        pos_sum   = SUM_W'(pos_reg) + SUM_W'(mul_res);
        vel_sum   = SUM_W'(vel_reg) + SUM_W'(mul_res);
        pos_sat   = sat_w(pos_sum, POS_W);
        vel_sat   = sat_w(vel_sum, VEL_W);
        turns_sat = sat_w(SUM_W'(mul_res), TURNS_W);
    end

    always_comb begin
        mul_req.start       = mul_start;
        mul_req.short_shift = (op_reg == OP_PCOR) || (op_reg == OP_VCOR);
        case (op_reg)
            OP_PRED: begin
                mul_req.x = XW'(vel_reg);
                mul_req.b = step_time_reg;
            end
            OP_PCOR: begin
                mul_req.x = err_reg;
                mul_req.b = pos_gain_reg;
            end
            OP_VCOR: begin
                mul_req.x = err_reg <<< VCOR_SHIFT;
                mul_req.b = vel_gain_reg;
            end
            OP_POUT: begin
                mul_req.x = XW'(pos_reg);
                mul_req.b = inv_cpr_reg;
            end
            OP_VOUT: begin
                mul_req.x = XW'(vel_reg);
                mul_req.b = inv_cpr_reg;
            end
            default: begin
                mul_req.x = '0;
                mul_req.b = '0;
            end
        endcase
        rem_req.start    = rem_start;
        rem_req.divisor  = cpr;
        rem_req.dividend = FRAME_W'(dmag_reg);
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        mul_start  = 1'b0;
        rem_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_ISSUE;
                    op_next    = OP_PRED;
                end
            end
            S_ISSUE: begin
                mul_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (mul_rsp.done) begin
                    case (op_reg)
                        OP_PRED: begin
                            if (accepted_reg) begin
                                rem_start  = 1'b1;
                                state_next = S_REM;
                            end else begin
                                op_next    = OP_POUT;
                                state_next = S_ISSUE;
                            end
                        end
                        OP_PCOR: begin
                            op_next    = OP_VCOR;
                            state_next = S_ISSUE;
                        end
                        OP_VCOR: begin
                            op_next    = OP_POUT;
                            state_next = S_ISSUE;
                        end
                        OP_POUT: begin
                            op_next    = OP_VOUT;
                            state_next = S_ISSUE;
                        end
                        OP_VOUT: begin
                            state_next = S_FINISH;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_REM: begin
                if (rem_rsp.done) begin
                    state_next = S_UNWRAP;
                end
            end
            S_UNWRAP: begin
                state_next = S_ERR;
            end
            S_ERR: begin
                op_next    = OP_PCOR;
                state_next = S_ISSUE;
            end
            S_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        out_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_PRED;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpr_reg        <= CPR_RESET;
            step_time_reg  <= STEP_TIME_RESET;
            pos_gain_reg   <= POS_GAIN_RESET;
            vel_gain_reg   <= VEL_GAIN_RESET;
            inv_cpr_reg    <= INV_CPR_RESET;
            last_angle_reg <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            vel_reg        <= '0;
            missed_reg     <= '0;
            error_reg      <= 1'b0;
            accepted_reg   <= 1'b0;
            rejected_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_COUNTS_PER_REV: cpr_reg       <= cfg_wdata[CPR_REG_W-1:0];
                    CFG_STEP_TIME:      step_time_reg <= cfg_wdata;
                    CFG_POS_GAIN:       pos_gain_reg  <= cfg_wdata;
                    CFG_VEL_GAIN:       vel_gain_reg  <= cfg_wdata;
                    CFG_INV_CPR:        inv_cpr_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (take_in) begin
                        accepted_reg <= in_acc;
                        rejected_reg <= in_rej;
                        if (in_rej) begin
                            error_reg <= 1'b1;
                        end
                        if (!in_acc && missed_reg != MISSED_MAX) begin
                            missed_reg <= missed_reg + MISSED_W'(1);
                        end
                        if (db_lhs < db_rhs) begin
                            vel_reg <= '0;
                        end
                    end
                end
                S_WAIT: begin
                    if (mul_rsp.done) begin
                        case (op_reg)
                            OP_PRED: pos_reg <= pos_sat[POS_W-1:0];
                            OP_PCOR: pos_reg <= pos_sat[POS_W-1:0];
                            OP_VCOR: vel_reg <= vel_sat[VEL_W-1:0];
                            OP_POUT: pos_turns_reg <= turns_sat[TURNS_W-1:0];
                            OP_VOUT: vel_turns_reg <= turns_sat[TURNS_W-1:0];
                            default: ;
                        endcase
                    end
                end
                S_UNWRAP: begin
                    last_angle_reg <= angle_reg;
                    count_reg      <= count_reg + COUNT_W'(m_val);
                end
                S_ERR: begin
                    err_reg <= err_val;
                end
                default: ;
            endcase
        end
    end

    // tick payload captured at acceptance
    always_ff @(posedge aclk) begin
        if (take_in) begin
            angle_reg <= in_angle;
            dneg_reg  <= d_val[ANGLE_BITS];
            dmag_reg  <= d_abs[ANGLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_pos_reg    <= pos_turns_reg;
            out_vel_reg    <= vel_turns_reg;
            out_count_reg  <= count_reg;
            out_rej_reg    <= rejected_reg;
            out_err_reg    <= error_reg;
            out_missed_reg <= missed_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {OUT_PAD_W'(0), out_missed_reg, out_err_reg, out_rej_reg,
                       out_count_reg, out_vel_reg, out_pos_reg};

    `EATO_ASSERT_NOW(a_mul_done_in_wait, aclk, aresetn, mul_rsp.done, state_reg == S_WAIT)
    `EATO_ASSERT_NOW(a_rem_done_in_rem, aclk, aresetn, rem_rsp.done, state_reg == S_REM)
    `EATO_ASSERT_NEXT(a_no_frame_not_rejected, aclk, aresetn, take_in && !s_tuser, !rejected_reg)
    `EATO_ASSERT_NEXT(a_error_sticky, aclk, aresetn, error_reg, error_reg)

endmodule

`default_nettype wire

// ----- sim/eato_estimate_checker.sv -----
`timescale 1ns / 100ps
// Checker for the encoder angle tracking observer: predicts each tick's estimates and compares.
module eato_estimate_checker
    import eato_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [FRAME_W-1:0]    s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_W-1:0]      m_tdata,
    output int                    fail_count,
    output int                    pending
);

    localparam int ANGLE_W         = 14;
    localparam int FRAC_W          = 16;
    localparam int GAIN_SHIFT      = 24 - FRAC_W;
    localparam int TURN_SHIFT      = 32;
    localparam int HALF_BAND_SHIFT = FRAC_W + 1;
    localparam int VEL_SCALE       = 256;
    localparam int REPORT_MAX      = 100;
    localparam longint unsigned MAG_CAP = 64'd1 << 50;

    typedef struct {
        logic signed [TURNS_W-1:0] pos;
        logic signed [TURNS_W-1:0] vel;
        logic signed [COUNT_W-1:0] count;
        logic                      rejected;
        logic                      err_seen;
        logic [MISSED_W-1:0]       missed;
    } estimate_t;

    logic [CPR_REG_W-1:0]  cpr_reg;
    logic [CFG_DATA_W-1:0] step_reg;
    logic [CFG_DATA_W-1:0] pgain_reg;
    logic [CFG_DATA_W-1:0] vgain_reg;
    logic [CFG_DATA_W-1:0] inv_reg;

    logic [ANGLE_W-1:0]  prev_angle;
    logic [COUNT_W-1:0]  count_acc;
    longint              pos_est;
    longint              vel_est;
    logic [MISSED_W-1:0] miss_cnt;
    logic                sticky_err;

    estimate_t expected_estimates[$];
    int        mismatches = 0;
    int        backlog = 0;

    assign fail_count = mismatches;
    assign pending    = backlog;

    function automatic longint clamp(input longint v, input int w);
        longint lim;
        lim = longint'(1) << (w - 1);
        if (v > lim - 1)
            return lim - 1;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // magnitude product, truncated toward zero, capped at 2^50
    function automatic longint scaled_product(input longint x, input logic [31:0] b,
                                              input int sh);
        longint unsigned mag;
        logic [95:0]     prod;
        logic [95:0]     r;
        mag = (x < 0) ? -x : x;
        prod = {32'd0, mag} * {64'd0, b};
        r = prod >> sh;
        if (r > {32'd0, MAG_CAP})
            r = {32'd0, MAG_CAP};
        return (x < 0) ? -$signed(r[63:0]) : $signed(r[63:0]);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_MAX)
            $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    task automatic advance_observer(input logic present, input logic [FRAME_W-1:0] frame,
                                    output estimate_t est);
        logic            rejected;
        logic            taken;
        longint unsigned vel_mag;
        int              span;
        int              delta;
        int              wrap_d;
        longint          cnt;
        longint          err;
        rejected = present && (frame[ERR_BIT] || (^frame));
        taken = present && !rejected;
        if (rejected)
            sticky_err = 1'b1;

        // dead band of half the velocity gain
        vel_mag = (vel_est < 0) ? -vel_est : vel_est;
        if ((vel_mag << HALF_BAND_SHIFT) < ({32'd0, vgain_reg} << FRAC_W))
            vel_est = 0;
        pos_est = clamp(pos_est + scaled_product(vel_est, step_reg, TURN_SHIFT), POS_W);

        if (taken) begin
            span = (cpr_reg == '0) ? (1 << ANGLE_W) : int'(cpr_reg);
            delta = int'(frame[ANGLE_W-1:0]) - int'(prev_angle);
            wrap_d = delta % span;
            if (wrap_d < 0)
                wrap_d += span;
            if (wrap_d * 2 > span)
                wrap_d -= span;
            prev_angle = frame[ANGLE_W-1:0];
            count_acc = count_acc + 32'(wrap_d);
            cnt = longint'($signed(count_acc));
            err = cnt - (pos_est >>> FRAC_W);
            pos_est = clamp(pos_est + scaled_product(err, pgain_reg, GAIN_SHIFT), POS_W);
            vel_est = clamp(vel_est + scaled_product(err * VEL_SCALE, vgain_reg, GAIN_SHIFT),
                            VEL_W);
        end else if (miss_cnt != MISSED_MAX) begin
            miss_cnt++;
        end

        est.pos = 32'(clamp(scaled_product(pos_est, inv_reg, TURN_SHIFT), TURNS_W));
        est.vel = 32'(clamp(scaled_product(vel_est, inv_reg, TURN_SHIFT), TURNS_W));
        est.count = count_acc;
        est.rejected = rejected;
        est.err_seen = sticky_err;
        est.missed = miss_cnt;
    endtask

    always @(posedge aclk) begin : monitor
        estimate_t got;
        estimate_t want;
        if (!aresetn) begin
            cpr_reg = CPR_RESET;
            step_reg = STEP_TIME_RESET;
            pgain_reg = POS_GAIN_RESET;
            vgain_reg = VEL_GAIN_RESET;
            inv_reg = INV_CPR_RESET;
            prev_angle = '0;
            count_acc = '0;
            pos_est = 0;
            vel_est = 0;
            miss_cnt = '0;
            sticky_err = 1'b0;
            expected_estimates.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.pos = m_tdata[31:0];
                got.vel = m_tdata[63:32];
                got.count = m_tdata[95:64];
                got.rejected = m_tdata[96];
                got.err_seen = m_tdata[97];
                got.missed = m_tdata[113:98];
                if (expected_estimates.size() == 0) begin
                    report_mismatch("result transaction with no expectation waiting");
                end else begin
                    want = expected_estimates.pop_front();
                    check_field("position_turns", got.pos, want.pos);
                    check_field("velocity_turns", got.vel, want.vel);
                    check_field("total_count", got.count, want.count);
                    check_field("frame_rejected", got.rejected, want.rejected);
                    check_field("error_seen", got.err_seen, want.err_seen);
                    check_field("missed_updates", got.missed, want.missed);
                    check_field("padding", m_tdata[OUT_W-1:OUT_W-OUT_PAD_W], 0);
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_COUNTS_PER_REV: cpr_reg = cfg_wdata[CPR_REG_W-1:0];
                    CFG_STEP_TIME:      step_reg = cfg_wdata;
                    CFG_POS_GAIN:       pgain_reg = cfg_wdata;
                    CFG_VEL_GAIN:       vgain_reg = cfg_wdata;
                    CFG_INV_CPR:        inv_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_observer(s_tuser, s_tdata, want);
                expected_estimates.push_back(want);
            end
        end
        backlog = expected_estimates.size();
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the encoder angle tracking observer: stimulus, flow control and verdict.
module tb;
    import eato_pkg::*;

    localparam int ANGLE_W       = 14;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_TICKS   = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 200;
    localparam int FILL_TICKS    = 24;
    localparam int SPEED_MAX     = 700;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_pattern_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [FRAME_W-1:0]    s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;

    int fail_count;
    int pending;
    int cycle_cnt = 0;
    int stall_requests = 0;
    int burst_left = 0;
    bit gapless = 1'b0;

    logic [ANGLE_W-1:0] track_angle;
    int                 track_speed;

    always #5 aclk = ~aclk;

    encoder_angle_tracking_observer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    eato_estimate_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // even parity over all 16 bits unless bad_par
    function automatic logic [FRAME_W-1:0] enc_frame(input logic [ANGLE_W-1:0] angle,
                                                     input logic err_bit, input logic bad_par);
        logic [FRAME_W-2:0] body;
        body = {err_bit, angle};
        return {(^body) ^ bad_par, body};
    endfunction

    task automatic send_tick(input logic present, input logic [FRAME_W-1:0] frame);
        int idle;
        if (!gapless && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 64);
            if (idle > 0) begin
                s_tvalid <= 1'b0;
                repeat (idle) @(negedge aclk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= present;
        s_tdata <= frame;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic load_settings(input logic [31:0] cpr_word, input logic [31:0] step,
                                 input logic [31:0] pgain, input logic [31:0] vgain,
                                 input logic [31:0] inv);
        pause_sender();
        cfg_we <= 1'b1;
        cfg_addr <= CFG_COUNTS_PER_REV;
        cfg_wdata <= cpr_word;
        @(negedge aclk);
        cfg_addr <= CFG_STEP_TIME;
        cfg_wdata <= step;
        @(negedge aclk);
        cfg_addr <= CFG_POS_GAIN;
        cfg_wdata <= pgain;
        @(negedge aclk);
        cfg_addr <= CFG_VEL_GAIN;
        cfg_wdata <= vgain;
        @(negedge aclk);
        cfg_addr <= CFG_INV_CPR;
        cfg_wdata <= inv;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_settings(input bit wild);
        int          cpr;
        int          span;
        logic [31:0] inv;
        logic [31:0] word;
        case ($urandom_range(0, 5))
            0: cpr = 16384;
            1: cpr = 4096;
            2: cpr = $urandom_range(1, 16384);
            3: cpr = 0;
            4: cpr = $urandom_range(16385, 32767);
            default: cpr = 360;
        endcase
        span = (cpr == 0) ? (1 << ANGLE_W) : cpr;
        inv = (span == 1) ? 32'hFFFF_FFFF : 32'((64'd1 << 32) / span);
        word = ($urandom() & 32'hFFFF_8000) | cpr;
        if (wild)
            load_settings(word, $urandom(), $urandom(), $urandom(), $urandom());
        else
            load_settings(word, $urandom() >> $urandom_range(6, 20),
                          $urandom() >> $urandom_range(4, 16),
                          $urandom() >> $urandom_range(4, 20), inv);
    endtask

    // mostly a smoothly moving encoder, plus dropouts, faults and jumps
    task automatic random_tick();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            track_speed += int'($urandom_range(0, 8)) - 4;
            if (track_speed > SPEED_MAX)
                track_speed = SPEED_MAX;
            if (track_speed < -SPEED_MAX)
                track_speed = -SPEED_MAX;
            track_angle = track_angle + 14'(track_speed);
            send_tick(1'b1, enc_frame(track_angle, 1'b0, 1'b0));
        end else if (pick < 78) begin
            send_tick(1'b0, 16'($urandom()));
        end else if (pick < 86) begin
            send_tick(1'b1, enc_frame(14'($urandom()), 1'b1, 1'($urandom())));
        end else if (pick < 93) begin
            send_tick(1'b1, enc_frame(14'($urandom()), 1'b0, 1'b1));
        end else begin
            track_angle = 14'($urandom());
            send_tick(1'b1, enc_frame(track_angle, 1'b0, 1'b0));
        end
    endtask

    initial begin : receiver
        rx_pattern_t pattern;
        int          left;
        int          beat;
        int          seen;
        pattern = RX_OPEN;
        left = 0;
        beat = 0;
        seen = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_requests != seen) begin
                seen = stall_requests;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (left == 0) begin
                pattern = rx_pattern_t'($urandom_range(0, 3));
                left = $urandom_range(16, 160);
            end
            left--;
            beat++;
            case (pattern)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= (beat % 5 == 0);
                default:   m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("encoder_angle_tracking_observer verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [ANGLE_W-1:0] a;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_COUNTS_PER_REV;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        track_angle = '0;
        track_speed = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: absent, good, wrapping and rejected frames
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b1, enc_frame(14'h0000, 1'b0, 1'b0));
        send_tick(1'b1, enc_frame(14'h3FFF, 1'b0, 1'b0));
        send_tick(1'b1, enc_frame(14'h1FFF, 1'b0, 1'b0));
        send_tick(1'b1, enc_frame(14'h0000, 1'b1, 1'b0));
        send_tick(1'b1, enc_frame(14'h1234, 1'b0, 1'b1));
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b1, 16'h0000);
        send_tick(1'b0, 16'h0000);

        // full-scale gains, zero counts per rev: drive into saturation both ways
        load_settings(32'd0, '1, '1, '1, '1);
        for (int k = 0; k < 5; k++)
            send_tick(1'b1, enc_frame((k % 2 == 0) ? 14'h2000 : 14'h0000, 1'b0, 1'b0));
        send_tick(1'b0, 16'h0000);
        a = 14'h2000;
        for (int k = 0; k < 5; k++) begin
            a = a + 14'h2001;
            send_tick(1'b1, enc_frame(a, 1'b0, 1'b0));
        end
        send_tick(1'b0, 16'h0000);

        // one count per rev, all gains zero; upper data bits must be ignored
        load_settings(32'hFFFF_8001, '0, '0, '0, '0);
        send_tick(1'b1, enc_frame(14'h3FFF, 1'b0, 1'b0));
        send_tick(1'b1, enc_frame(14'h0001, 1'b0, 1'b0));

        // largest counts per rev
        load_settings('1, STEP_TIME_RESET, POS_GAIN_RESET, VEL_GAIN_RESET, INV_CPR_RESET);
        send_tick(1'b1, enc_frame(14'h3FFF, 1'b0, 1'b0));
        send_tick(1'b1, enc_frame(14'h0000, 1'b0, 1'b0));
        send_tick(1'b1, enc_frame(14'h2000, 1'b0, 1'b0));
        track_angle = 14'h2000;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: load_settings({17'd0, CPR_RESET}, STEP_TIME_RESET, POS_GAIN_RESET,
                                 VEL_GAIN_RESET, INV_CPR_RESET);
                2: random_settings(1'b1);
                default: random_settings(1'b0);
            endcase
            for (int k = 0; k < PHASE_TICKS; k++) begin
                if ((p == 0 && k == 40) || $urandom_range(0, 299) == 0)
                    stall_requests++;
                if ((p == 1 && k == 75) || $urandom_range(0, 199) == 0)
                    pause_sender();
                random_tick();
            end
        end

        // gapless run of dropouts and faulted frames
        gapless = 1'b1;
        for (int k = 0; k < FILL_TICKS; k++) begin
            if (k % 3 == 0)
                send_tick(1'b1, enc_frame(14'($urandom()), 1'b1, 1'b0));
            else
                send_tick(1'b0, 16'($urandom()));
        end
        send_tick(1'b1, enc_frame(track_angle, 1'b0, 1'b0));
        send_tick(1'b0, 16'h0000);
        send_tick(1'b1, enc_frame(track_angle, 1'b0, 1'b1));
        gapless = 1'b0;

        pause_sender();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("encoder_angle_tracking_observer verification clean");
        else
            $display("encoder_angle_tracking_observer verification failed");
        $finish;
    end

endmodule
